// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds at the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/i64dec_pkg.sv
// ---------------------------------------------------------------------------
// i64dec_pkg
// shared widths, character codes and bcd helpers for the decimal text core
// ---------------------------------------------------------------------------
package i64dec_pkg;

    localparam int VALUE_BITS        = 64;
    localparam int LIMIT_BITS        = 8;
    localparam int CHAR_BITS         = 7;
    localparam int VALUE_WIDTH_DEF   = 64;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_END   = 7'd0;

    // decimal digits needed for a magnitude up to 2**(w-1)
    function automatic int num_digits(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

    // double-dabble digit correction
    function automatic logic [3:0] add3(input logic [3:0] d);
        return (d > 4'd4) ? d + 4'd3 : d;
    endfunction

    typedef struct packed {
        logic busy;
        logic done;
    } t_dab_stat;

endpackage

// File: design/i64dec_in_if.sv
// ---------------------------------------------------------------------------
// i64dec_in_if
// input channel: signed value and character limit
// ---------------------------------------------------------------------------
interface i64dec_in_if
    import i64dec_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic        [LIMIT_BITS-1:0] char_limit;

    modport source (output valid, output value, output char_limit, input ready);
    modport sink   (input valid, input value, input char_limit, output ready);
endinterface

// File: design/i64dec_out_if.sv
// ---------------------------------------------------------------------------
// i64dec_out_if
// output channel: one ascii character per beat, last on the terminator
// ---------------------------------------------------------------------------
interface i64dec_out_if
    import i64dec_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: design/int64_to_decimal_ascii_core.sv
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii_core
// signed integer to decimal ascii text, one character per output beat
// ---------------------------------------------------------------------------
//  channel   dir  fields                         beat
//  i_in      in   value[63:0] s, char_limit[7:0] one number to print
//  o_out     out  character[6:0], last           one character, last on nul
//
//  steps: take the number, run the serial bcd conversion, emit the sign,
//  then one character per bcd digit position (leading zeros
//  dropped without a beat) until the limit is hit, close the digits
//  and emit the terminator; a zero limit goes straight to the terminator
//  reset: synchronous, active low, clears the sequencer and output valid
//  stalls: a full output register holds the sequencer; a new number is
//  taken while the terminator still waits to be collected
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module int64_to_decimal_ascii_core
    import i64dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i64dec_in_if.sink     i_in,
    i64dec_out_if.source  o_out
);

    localparam int BcdDigits = num_digits(VALUE_WIDTH);
    localparam int NdigW     = $clog2(BcdDigits + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT,
        S_TERM
    } t_state;

    t_state                  r_state,     n_state;
    logic                    r_neg,       n_neg;
    logic [LIMIT_BITS-1:0]   r_left,      n_left;
    logic [4*BcdDigits-1:0]  r_dig,       n_dig;
    logic [NdigW-1:0]        r_ndig,      n_ndig;
    logic                    r_started,   n_started;
    logic                    r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]    r_char,      n_char;
    logic                    r_last,      n_last;

    logic                    in_fire;
    logic                    can_load;
    logic                    in_neg;
    logic [VALUE_WIDTH-1:0]  in_raw;
    logic [VALUE_WIDTH-1:0]  in_mag;
    logic [3:0]              top_dig;
    logic [4*BcdDigits-1:0]  dab_bcd;
    t_dab_stat               s_dab;

    // only the low VALUE_WIDTH bits count, as two's complement
    assign in_raw  = i_in.value[VALUE_WIDTH-1:0];
    assign in_neg  = in_raw[VALUE_WIDTH-1];
    assign in_mag  = in_neg ? (~in_raw + VALUE_WIDTH'(1)) : in_raw;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    // output register free this cycle, or emptied by the sink
    assign can_load = !r_out_valid || o_out.ready;
    assign top_dig  = r_dig[4*BcdDigits-1 -: 4];

    i64dec_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .BCD_DIGITS  (BcdDigits)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_mag   (in_mag),
        .o_bcd   (dab_bcd),
        .o_stat  (s_dab)
    );

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_left      = r_left;
        n_dig       = r_dig;
        n_ndig      = r_ndig;
        n_started   = r_started;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_neg   = in_neg;
                    n_left  = i_in.char_limit;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (s_dab.done) begin
                    n_dig     = dab_bcd;
                    n_ndig    = NdigW'(BcdDigits);
                    n_started = 1'b0;
                    if (r_left == '0) begin
                        n_state = S_TERM;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_SIGN: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_left      = r_left - LIMIT_BITS'(1);
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (r_ndig == '0 || r_left == '0) begin
                    n_state = S_TERM;
                end else if (!r_started && top_dig == 4'd0 && r_ndig > NdigW'(1)) begin
                    // leading zero, dropped without a beat
                    n_dig  = {r_dig[4*BcdDigits-5:0], 4'd0};
                    n_ndig = r_ndig - NdigW'(1);
                end else if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO + {3'd0, top_dig};
                    n_last      = 1'b0;
                    n_dig       = {r_dig[4*BcdDigits-5:0], 4'd0};
                    n_ndig      = r_ndig - NdigW'(1);
                    n_left      = r_left - LIMIT_BITS'(1);
                    n_started   = 1'b1;
                end
            end
            S_TERM: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_END;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_ndig      <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
            r_ndig      <= n_ndig;
            r_left      <= n_left;
        end
        r_neg  <= n_neg;
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    `ASSERT_ALWAYS(a_last_is_nul, !(r_out_valid && r_last) || r_char == CHAR_END, "last beat not nul")
    `ASSERT_ALWAYS(a_conv_busy, !s_dab.busy || r_state == S_CONV, "converter busy outside conversion")
    `ASSERT_ALWAYS(a_ndig_range, r_ndig <= NdigW'(BcdDigits), "digit count beyond bcd width")

endmodule

// File: design/i64dec_dabble.sv
// ---------------------------------------------------------------------------
// i64dec_dabble
// bit-serial binary to bcd converter, one magnitude bit per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i64dec_dabble
    import i64dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int BCD_DIGITS  = num_digits(VALUE_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_WIDTH-1:0]    i_mag,
    output logic [4*BCD_DIGITS-1:0]   o_bcd,
    output t_dab_stat                 o_stat
);

    localparam int CntW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]  r_mag;
    logic [4*BCD_DIGITS-1:0] r_bcd;
    logic [4*BCD_DIGITS-1:0] n_adj;
    logic [CntW-1:0]         r_cnt;
    logic                    r_busy;
    logic                    r_done;

    // correct every digit ahead of the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            n_adj[4*i +: 4] = add3(r_bcd[4*i +: 4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(VALUE_WIDTH);
                r_mag  <= i_mag;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {n_adj[4*BCD_DIGITS-2:0], r_mag[VALUE_WIDTH-1]};
                r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_bcd       = r_bcd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `ASSERT_ALWAYS(a_busy_cnt, !r_busy || r_cnt != '0, "dabble busy with zero count")
    `ASSERT_NEXT(a_done_pulse, r_done, !r_done && !r_busy, "dabble done not a single pulse")
    `ASSERT_ALWAYS(a_start_idle, !i_start || !r_busy, "dabble restarted while busy")

endmodule
